FILE: rtl/core/mrpts_pkg.sv
package mrpts_pkg;

    localparam int TIME_WIDTH = 48;

    typedef enum logic [1:0] {
        CFG_WARMUP_LENGTH = 2'd0,
        CFG_HALF_SAMPLE   = 2'd1,
        CFG_TICK_LENGTH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]            data_byte;
        logic [TIME_WIDTH-1:0] host_time;
    } item_t;

    typedef struct packed {
        logic [47:0]           accel_packed;
        logic [47:0]           gyro_packed;
        logic [35:0]           mag_packed;
        logic [TIME_WIDTH-1:0] sample_time;
        logic                  in_warmup;
        logic                  second_half;
        logic [8:0]            buttons;
        logic [7:0]            trigger_value;
        logic [7:0]            battery_code;
        logic                  battery_changed;
        logic signed [11:0]    temperature;
        logic [15:0]           lost_reports;
    } result_t;

    // decoded report handed from the byte collector to the timing engine
    typedef struct packed {
        logic [3:0]            seq_num;
        logic [15:0]           ticks;
        logic [7:0]            battery;
        logic [TIME_WIDTH-1:0] host;
        logic [47:0]           accel0;
        logic [47:0]           gyro0;
        logic [47:0]           accel1;
        logic [47:0]           gyro1;
        logic [35:0]           mag;
        logic [8:0]            buttons;
        logic [7:0]            trigger_value;
        logic [11:0]           temperature;
    } report_t;

    typedef struct packed {
        logic [23:0] warmup_length;
        logic [15:0] half_sample_offset;
        logic [7:0]  tick_length;
    } cfg_t;

endpackage

FILE: rtl/core/mrpts_fifo.sv
module mrpts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/mrpts_front.sv
module mrpts_front #(
    parameter int REPORT_LENGTH = 49
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mrpts_pkg::item_t   item,
    output logic               full,
    output logic               rec_push,
    output mrpts_pkg::report_t rec,
    input  logic               rec_full
);

    localparam int PW = $clog2(REPORT_LENGTH);
    localparam int NB = 44;

    logic [PW-1:0] pos_reg;
    logic [7:0]    bytes_reg [NB];
    logic [7:0]    b [NB];
    logic          last, take;

    assign last     = (pos_reg == PW'(REPORT_LENGTH - 1));
    assign full     = last && rec_full;
    assign take     = push && !full;
    assign rec_push = take && last;

    // the final byte may itself be one of the decoded ones on short reports
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            b[i] = (last && pos_reg == PW'(i)) ? item.data_byte : bytes_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NB; i++)
        begin
            if (take && pos_reg == PW'(i))
            begin
                bytes_reg[i] <= item.data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (take)
        begin
            pos_reg <= last ? '0 : pos_reg + 1'b1;
        end
    end

    function automatic logic [15:0] w16(input logic [7:0] lo, input logic [7:0] hi);
        return {hi ^ 8'h80, lo};
    endfunction

    always_comb
    begin
        rec.seq_num       = b[4][3:0];
        rec.ticks         = {b[11], b[43]};
        rec.battery       = b[12];
        rec.host          = item.host_time;
        rec.accel0        = {w16(b[17], b[18]), w16(b[15], b[16]), w16(b[13], b[14])};
        rec.accel1        = {w16(b[23], b[24]), w16(b[21], b[22]), w16(b[19], b[20])};
        rec.gyro0         = {w16(b[29], b[30]), w16(b[27], b[28]), w16(b[25], b[26])};
        rec.gyro1         = {w16(b[35], b[36]), w16(b[33], b[34]), w16(b[31], b[32])};
        rec.mag           = {b[41][3:0], b[42], b[40], b[41][7:4], b[38][3:0], b[39]};
        rec.buttons       = {b[3][4], b[3][3], b[3][0], b[2][7:4], b[1][3], b[1][0]};
        rec.trigger_value = b[6];
        rec.temperature   = {b[37], b[38][7:4]};
    end

endmodule

FILE: rtl/core/mrpts_back.sv
module mrpts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mrpts_pkg::cfg_t    cfg,
    input  logic               rec_empty,
    input  mrpts_pkg::report_t rec,
    output logic               rec_pop,
    output logic               res_push,
    output mrpts_pkg::result_t res,
    input  logic               res_full
);

    localparam int TW = mrpts_pkg::TIME_WIDTH;
    localparam int OW = TW + 1;
    localparam int CHUNKS = (OW + 15) / 16;
    localparam int NW = CHUNKS * 16;
    localparam int SW = $clog2(CHUNKS + 1);
    // ceil(2^36 / 1000): exact quotient for any dividend below 2^26
    localparam logic [26:0] RECIP = 27'd68719477;

    typedef enum logic [2:0] {S_IDLE, S_TIME, S_DIV, S_OUT0, S_OUT1} state_t;

    state_t               state_reg;
    mrpts_pkg::report_t   r_reg;
    logic                 first_seen_reg;
    logic [3:0]           last_seq_reg;
    logic [15:0]          last_ticks_reg;
    logic [TW-1:0]        sensor_reg;
    logic signed [OW-1:0] offset_reg;
    logic [TW-1:0]        warm_start_reg;
    logic [TW-1:0]        prev_host_reg;
    logic [7:0]           rec_batt_reg;
    logic [15:0]          lost_reg;
    logic                 warm_reg;
    logic                 changed_reg;
    logic [TW-1:0]        packet_reg;
    logic [NW-1:0]        num_reg;
    logic [NW-1:0]        quo_reg;
    logic [9:0]           rem_reg;
    logic [SW-1:0]        step_reg;
    logic                 phase_reg;
    logic [15:0]          digit_reg;
    logic [25:0]          x_reg;

    logic                 warm;
    logic [3:0]           delta;
    logic [16:0]          lost_sum;
    logic [15:0]          tick_diff;
    logic [23:0]          tick_prod;
    logic signed [OW-1:0] cand;
    logic [TW-1:0]        host_diff;
    logic [25:0]          div_x;
    logic [52:0]          div_prod;

    assign rec_pop   = (state_reg == S_IDLE) && !rec_empty;
    assign warm      = ((prev_host_reg - warm_start_reg) < TW'(cfg.warmup_length));
    assign delta     = rec.seq_num - last_seq_reg;
    assign lost_sum  = {1'b0, lost_reg} + 17'(delta - 4'd1);
    assign tick_diff = rec.ticks - last_ticks_reg;
    assign tick_prod = tick_diff * cfg.tick_length;
    assign host_diff = r_reg.host - sensor_reg;
    assign cand      = {host_diff[TW-1], host_diff};

    // divide by 1000 one 16-bit digit at a time: reciprocal multiply, then remainder
    assign div_x    = {rem_reg, num_reg[NW-1 -: 16]};
    assign div_prod = 53'(div_x) * 53'(RECIP);

    assign res_push = ((state_reg == S_OUT0) || (state_reg == S_OUT1)) && !res_full;

    always_comb
    begin
        res.accel_packed    = (state_reg == S_OUT1) ? r_reg.accel1 : r_reg.accel0;
        res.gyro_packed     = (state_reg == S_OUT1) ? r_reg.gyro1 : r_reg.gyro0;
        res.mag_packed      = r_reg.mag;
        res.sample_time     = (state_reg == S_OUT1) ? packet_reg
                              : packet_reg - TW'(cfg.half_sample_offset);
        res.in_warmup       = warm_reg;
        res.second_half     = (state_reg == S_OUT1);
        res.buttons         = r_reg.buttons;
        res.trigger_value   = r_reg.trigger_value;
        res.battery_code    = r_reg.battery;
        res.battery_changed = changed_reg;
        res.temperature     = r_reg.temperature;
        res.lost_reports    = lost_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            r_reg <= rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_seen_reg <= 1'b0;
            last_seq_reg   <= '0;
            last_ticks_reg <= '0;
            sensor_reg     <= '0;
            offset_reg     <= '0;
            warm_start_reg <= '0;
            prev_host_reg  <= '0;
            rec_batt_reg   <= '0;
            lost_reg       <= '0;
            warm_reg       <= 1'b0;
            changed_reg    <= 1'b0;
            packet_reg     <= '0;
            num_reg        <= '0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            step_reg       <= '0;
            phase_reg      <= 1'b0;
            digit_reg      <= '0;
            x_reg          <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!rec_empty)
                    begin
                        last_seq_reg   <= rec.seq_num;
                        last_ticks_reg <= rec.ticks;
                        prev_host_reg  <= rec.host;
                        if (!first_seen_reg)
                        begin
                            first_seen_reg <= 1'b1;
                            warm_start_reg <= rec.host;
                            sensor_reg     <= rec.host;
                            rec_batt_reg   <= rec.battery;
                        end
                        else
                        begin
                            warm_reg   <= warm;
                            sensor_reg <= sensor_reg + TW'(tick_prod);
                            if (delta > 4'd1)
                            begin
                                lost_reg <= lost_sum[16] ? 16'hffff : lost_sum[15:0];
                            end
                            changed_reg <= !warm && (rec.battery != rec_batt_reg);
                            if (!warm)
                            begin
                                rec_batt_reg <= rec.battery;
                            end
                            state_reg <= S_TIME;
                        end
                    end
                end
                S_TIME:
                begin
                    packet_reg <= sensor_reg + offset_reg[TW-1:0];
                    if (offset_reg > cand)
                    begin
                        offset_reg <= cand;
                        state_reg  <= S_OUT0;
                    end
                    else if (!warm_reg)
                    begin
                        num_reg   <= NW'(cand - offset_reg) + NW'(500);
                        quo_reg   <= '0;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT0;
                    end
                end
                S_DIV:
                begin
                    if (!phase_reg)
                    begin
                        digit_reg <= div_prod[36 +: 16];
                        x_reg     <= div_x;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        num_reg   <= {num_reg[NW-17:0], 16'h0000};
                        quo_reg   <= {quo_reg[NW-17:0], digit_reg};
                        rem_reg   <= 10'(x_reg - 26'(digit_reg) * 26'd1000);
                        step_reg  <= step_reg + 1'b1;
                        phase_reg <= 1'b0;
                        if (step_reg == SW'(CHUNKS - 1))
                        begin
                            offset_reg <= offset_reg
                                          + $signed(OW'({quo_reg[NW-17:0], digit_reg}));
                            state_reg  <= S_OUT0;
                        end
                    end
                end
                S_OUT0:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_OUT1;
                    end
                end
                S_OUT1:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/motion_report_parser_time_sync.sv
// A report's first result is queued after its last byte, after a divide by 1000 in
// four 16-bit digits (reciprocal multiply, then remainder) where the offset may rise
// outside warm-up; the second result follows. Input: one byte per cycle unless the
// two-entry report queue, which decouples the timing engine, is full at a last byte.
// Reset (rst_n, async, active low) clears clocks, counters and queues and loads
// the register defaults: warmup 1000000, half-sample 5650, tick 10.
module motion_report_parser_time_sync #(
    parameter int REPORT_LENGTH = 49
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mrpts_pkg::item_t    item,
    output logic                empty,
    input  logic                pop,
    output mrpts_pkg::result_t  result,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int RW = $bits(mrpts_pkg::report_t);
    localparam int OW = $bits(mrpts_pkg::result_t);

    mrpts_pkg::cfg_t    cfg_reg;
    mrpts_pkg::report_t rec_in, rec_out;
    mrpts_pkg::result_t res_in;
    logic               rec_push, rec_pop, rec_full, rec_empty;
    logic               res_push, res_full;
    logic [RW-1:0]      rec_bits;
    logic [OW-1:0]      res_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warmup_length      <= 24'd1000000;
            cfg_reg.half_sample_offset <= 16'd5650;
            cfg_reg.tick_length        <= 8'd10;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mrpts_pkg::CFG_WARMUP_LENGTH: cfg_reg.warmup_length <= cfg_data;
                mrpts_pkg::CFG_HALF_SAMPLE:   cfg_reg.half_sample_offset <= cfg_data[15:0];
                mrpts_pkg::CFG_TICK_LENGTH:   cfg_reg.tick_length <= cfg_data[7:0];
                default:                      ;
            endcase
        end
    end

    mrpts_front #(.REPORT_LENGTH(REPORT_LENGTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .rec_push (rec_push),
        .rec      (rec_in),
        .rec_full (rec_full)
    );

    mrpts_fifo #(.WIDTH(RW), .DEPTH(2)) u_rec_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .rd_en   (rec_pop),
        .rd_data (rec_bits),
        .full    (rec_full),
        .empty   (rec_empty)
    );

    assign rec_out = mrpts_pkg::report_t'(rec_bits);

    mrpts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec_empty (rec_empty),
        .rec       (rec_out),
        .rec_pop   (rec_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    mrpts_fifo #(.WIDTH(OW), .DEPTH(2)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_bits),
        .full    (res_full),
        .empty   (empty)
    );

    assign result = mrpts_pkg::result_t'(res_bits);

endmodule

FILE: rtl/core/mrpts_checker.sv
module mrpts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input mrpts_pkg::result_t result
);

    // first half is always followed by its second half
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !result.second_half |=> !empty && result.second_half)
        else $error("second half missing after first half");

    a_mag: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !result.second_half |=> result.mag_packed == $past(result.mag_packed))
        else $error("halves of one report disagree on magnetometer");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result vanished");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result))
        else $error("waiting result changed");

endmodule

bind motion_report_parser_time_sync mrpts_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

FILE: tb/tb_top.sv
module tb_top;

    localparam int REPORT_LEN = 49;
    localparam longint unsigned CYCLE_LIMIT = 2000000;
    localparam logic [47:0] TMASK = 48'hffff_ffff_ffff;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    mrpts_pkg::item_t   item;
    logic               empty;
    logic               pop;
    mrpts_pkg::result_t result;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    motion_report_parser_time_sync i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]         rpt [REPORT_LEN];
    int                 pos;
    bit                 seen_first;
    logic [3:0]         last_seq;
    logic [15:0]        last_ticks;
    logic [47:0]        sens_time;
    longint             offset_est;
    logic [47:0]        warm_start;
    logic [47:0]        prev_host;
    logic [7:0]         rec_batt;
    int                 lost_cnt;
    logic [23:0]        warmup_len;
    logic [15:0]        half_off;
    logic [7:0]         tick_len;

    mrpts_pkg::result_t sample_q [$];
    int                 errors;
    longint unsigned    cycles;
    bit                 hold_off;
    int                 hold_cycles;
    bit                 sink_idle_off;

    // generator-side state of the synthetic device
    logic [3:0]  gen_seq;
    logic [15:0] gen_ticks;
    logic [47:0] gen_host;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] word_at(int lo);
        return {rpt[lo + 1], rpt[lo]} ^ 16'h8000;
    endfunction

    function automatic logic [47:0] triple_at(int base);
        return {word_at(base + 4), word_at(base + 2), word_at(base)};
    endfunction

    function automatic longint as_signed48(logic [47:0] v);
        return longint'({{16{v[47]}}, v});
    endfunction

    task automatic predict_byte(mrpts_pkg::item_t it);
        logic [3:0]  seq;
        logic [15:0] ticks;
        logic [7:0]  batt;
        logic [47:0] host;
        logic [3:0]  delta;
        logic [47:0] pkt_time;
        longint      cand;
        bit          warm;
        bit          changed;
        mrpts_pkg::result_t r;
        host = it.host_time;
        rpt[pos] = it.data_byte;
        if (pos < REPORT_LEN - 1)
        begin
            pos++;
            return;
        end
        pos = 0;
        seq = rpt[4][3:0];
        ticks = {rpt[11], rpt[43]};
        batt = rpt[12];
        if (!seen_first)
        begin
            seen_first = 1;
            warm_start = host;
            prev_host = host;
            sens_time = host;
            last_seq = seq;
            last_ticks = ticks;
            rec_batt = batt;
            return;
        end
        warm = (48'(prev_host - warm_start)) < {24'd0, warmup_len};
        prev_host = host;
        delta = seq - last_seq;
        last_seq = seq;
        if (delta > 1)
        begin
            lost_cnt += delta - 1;
            if (lost_cnt > 65535)
                lost_cnt = 65535;
        end
        sens_time = 48'(sens_time + 48'(16'(ticks - last_ticks)) * tick_len);
        last_ticks = ticks;
        pkt_time = 48'(sens_time + 48'(offset_est));
        cand = as_signed48(48'(host - sens_time));
        if (offset_est > cand)
            offset_est = cand;
        else if (!warm)
            offset_est += (cand - offset_est + 500) / 1000;
        changed = 0;
        if (!warm)
        begin
            changed = batt != rec_batt;
            rec_batt = batt;
        end
        r.mag_packed = {12'({rpt[41], rpt[42]}), 12'({rpt[40], rpt[41][7:4]}),
                        12'({rpt[38], rpt[39]})};
        r.in_warmup = warm;
        r.buttons = {rpt[3][4], rpt[3][3], rpt[3][0], rpt[2][7:4], rpt[1][3], rpt[1][0]};
        r.trigger_value = rpt[6];
        r.battery_code = batt;
        r.battery_changed = changed;
        r.temperature = {rpt[37], rpt[38][7:4]};
        r.lost_reports = 16'(lost_cnt);
        for (int k = 0; k < 2; k++)
        begin
            r.accel_packed = triple_at(k ? 19 : 13);
            r.gyro_packed = triple_at(k ? 31 : 25);
            r.sample_time = k ? pkt_time : 48'(pkt_time - half_off);
            r.second_half = k[0];
            sample_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    endtask

    // result checker and receiver
    always @(posedge clk)
    begin
        mrpts_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (sample_q.size() == 0)
                report_mismatch("unexpected sample", 64'(result.sample_time), 0);
            else
            begin
                want = sample_q.pop_front();
                if (result.accel_packed !== want.accel_packed)
                    report_mismatch("accel", result.accel_packed, want.accel_packed);
                if (result.gyro_packed !== want.gyro_packed)
                    report_mismatch("gyro", result.gyro_packed, want.gyro_packed);
                if (result.mag_packed !== want.mag_packed)
                    report_mismatch("mag", result.mag_packed, want.mag_packed);
                if (result.sample_time !== want.sample_time)
                    report_mismatch("sample_time", result.sample_time, want.sample_time);
                if (result.in_warmup !== want.in_warmup)
                    report_mismatch("in_warmup", result.in_warmup, want.in_warmup);
                if (result.second_half !== want.second_half)
                    report_mismatch("second_half", result.second_half, want.second_half);
                if (result.buttons !== want.buttons)
                    report_mismatch("buttons", result.buttons, want.buttons);
                if (result.trigger_value !== want.trigger_value)
                    report_mismatch("trigger", result.trigger_value, want.trigger_value);
                if (result.battery_code !== want.battery_code)
                    report_mismatch("battery", result.battery_code, want.battery_code);
                if (result.battery_changed !== want.battery_changed)
                    report_mismatch("batt_changed", result.battery_changed,
                                    want.battery_changed);
                if (result.temperature !== want.temperature)
                    report_mismatch("temperature", result.temperature, want.temperature);
                if (result.lost_reports !== want.lost_reports)
                    report_mismatch("lost", result.lost_reports, want.lost_reports);
            end
        end
    end

    // pop pattern: random gaps, long hold-off on request
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off)
        begin
            hold_cycles <= 400;
            pop <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else if (sink_idle_off)
            pop <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                pop <= 1'b1;
            else if (r < 97)
            begin
                pop <= 1'b0;
                hold_cycles <= $urandom_range(0, 3);
            end
            else
            begin
                pop <= 1'b0;
                hold_cycles <= $urandom_range(10, 60);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic [47:0] host, bit gaps);
        mrpts_pkg::item_t it;
        int g;
        if (gaps)
        begin
            g = $urandom_range(0, 99);
            g = (g < 75) ? 0 : (g < 97) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            repeat (g)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        it.data_byte = b;
        it.host_time = host;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_byte(it);
    endtask

    // one report; plausible==0 randomises everything
    task automatic send_report(bit plausible, bit gaps);
        logic [7:0] b [REPORT_LEN];
        logic [47:0] step;
        for (int i = 0; i < REPORT_LEN; i++)
            b[i] = 8'($urandom);
        if (plausible)
        begin
            gen_seq = gen_seq + (($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd1);
            gen_ticks = gen_ticks + 16'($urandom_range(50, 150));
            step = 48'($urandom_range(500, 1500));
            b[4] = {4'($urandom), gen_seq};
            b[11] = gen_ticks[15:8];
            b[43] = gen_ticks[7:0];
            if ($urandom_range(0, 7) != 0)
                b[12] = 8'($urandom_range(0, 5));
        end
        else
            step = {16'($urandom), 32'($urandom)};
        gen_host = gen_host + step;
        for (int i = 0; i < REPORT_LEN; i++)
            send_byte(b[i], (i == REPORT_LEN - 1) ? gen_host : {16'($urandom), 32'($urandom)},
                      gaps);
    endtask

    task automatic drain_all();
        push <= 1'b0;
        sink_idle_off = 1;
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        sink_idle_off = 0;
    endtask

    task automatic write_reg(mrpts_pkg::cfg_index_t idx, logic [23:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mrpts_pkg::CFG_WARMUP_LENGTH: warmup_len = val;
            mrpts_pkg::CFG_HALF_SAMPLE:   half_off = val[15:0];
            mrpts_pkg::CFG_TICK_LENGTH:   tick_len = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // directed: extreme bytes, wrap of host time, skipped sequences
    task automatic test_directed();
        logic [7:0] fill;
        for (int r = 0; r < 4; r++)
        begin
            fill = (r % 2) ? 8'hff : 8'h00;
            gen_host = (r == 3) ? 48'h0 : TMASK - 48'd10;
            for (int i = 0; i < REPORT_LEN; i++)
                send_byte(fill, gen_host, 0);
        end
        drain_all();
    endtask

    task automatic test_defaults_random(int n);
        for (int i = 0; i < n; i++)
            send_report($urandom_range(0, 9) != 0, 1);
        drain_all();
    endtask

    task automatic test_register_extremes();
        write_reg(mrpts_pkg::CFG_WARMUP_LENGTH, 24'd0);
        write_reg(mrpts_pkg::CFG_HALF_SAMPLE, 24'h00ffff);
        write_reg(mrpts_pkg::CFG_TICK_LENGTH, 24'd255);
        repeat (3) send_report(1, 1);
        drain_all();
        write_reg(mrpts_pkg::CFG_WARMUP_LENGTH, 24'hffffff);
        write_reg(mrpts_pkg::CFG_HALF_SAMPLE, 24'd0);
        write_reg(mrpts_pkg::CFG_TICK_LENGTH, 24'd1);
        repeat (3) send_report(1, 1);
        drain_all();
        write_reg(mrpts_pkg::CFG_WARMUP_LENGTH, 24'd3000);
        write_reg(mrpts_pkg::CFG_HALF_SAMPLE, 24'($urandom_range(0, 65535)));
        write_reg(mrpts_pkg::CFG_TICK_LENGTH, 24'($urandom_range(1, 255)));
        repeat (3) send_report(1, 1);
        drain_all();
    endtask

    // receiver stalls while sender keeps offering, so full must assert
    task automatic test_backpressure();
        hold_off = 1;
        repeat (2) @(posedge clk);
        hold_off = 0;
        repeat (5) send_report(1, 0);
        drain_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = mrpts_pkg::CFG_WARMUP_LENGTH;
        cfg_data = '0;
        cycles = 0;
        errors = 0;
        hold_off = 0;
        hold_cycles = 0;
        sink_idle_off = 0;
        pos = 0;
        seen_first = 0;
        last_seq = '0;
        last_ticks = '0;
        sens_time = '0;
        offset_est = 0;
        warm_start = '0;
        prev_host = '0;
        rec_batt = '0;
        lost_cnt = 0;
        warmup_len = 24'd1000000;
        half_off = 16'd5650;
        tick_len = 8'd10;
        gen_seq = '0;
        gen_ticks = '0;
        gen_host = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_defaults_random(4);
        test_register_extremes();
        test_backpressure();
        write_reg(mrpts_pkg::CFG_WARMUP_LENGTH, 24'd1000000);
        write_reg(mrpts_pkg::CFG_HALF_SAMPLE, 24'd5650);
        write_reg(mrpts_pkg::CFG_TICK_LENGTH, 24'd10);
        test_defaults_random(4);
        drain_all();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: motion_report_parser_time_sync.f
rtl/core/mrpts_pkg.sv
rtl/core/mrpts_fifo.sv
rtl/core/mrpts_front.sv
rtl/core/mrpts_back.sv
rtl/core/motion_report_parser_time_sync.sv
rtl/core/mrpts_checker.sv
tb/tb_top.sv
